/* rtl/core/mffd_pkg.sv */
// ---------------------------------------------------------------------------
// mffd_pkg
// Shared types and constants of the management-frame flood detector.
// ---------------------------------------------------------------------------
package mffd_pkg;

  localparam int RULE_COUNT = 3;

  localparam logic [3:0]  SUBTYPE_DISASSOC = 4'd10;
  localparam logic [3:0]  SUBTYPE_AUTH     = 4'd11;
  localparam logic [3:0]  SUBTYPE_DEAUTH   = 4'd12;
  localparam logic [15:0] MIN_FRAME_LEN    = 16'd24;

  localparam logic [1:0] RULE_DEAUTH   = 2'd0;
  localparam logic [1:0] RULE_DISASSOC = 2'd1;
  localparam logic [1:0] RULE_AUTH     = 2'd2;
  localparam logic [1:0] RULE_NONE     = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_WINDOW    = 3'd0;
  localparam logic [2:0] REG_COOLDOWN  = 3'd1;
  localparam logic [2:0] REG_DEAUTH    = 3'd2;
  localparam logic [2:0] REG_DISASSOC  = 3'd3;
  localparam logic [2:0] REG_AUTH      = 3'd4;

  typedef struct packed {
    logic [3:0]  frame_subtype;
    logic [7:0]  radio_channel;
    logic [47:0] bss_address;
    logic [47:0] source_address;
    logic [31:0] time_ms;
    logic [15:0] frame_length;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  attack_kind;
    logic [31:0] detected_at_ms;
    logic [6:0]  count_in_window;
    logic [7:0]  alert_channel;
    logic [3:0]  alert_subtype;
    logic [47:0] alert_bssid;
    logic [47:0] alert_sender;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture input word, start search
    logic scan;       // examine one entry
    logic claim;      // load entry state on a hit, claim chosen entry on a miss
    logic rd_ring;    // issue ring read of oldest slot
    logic evict;      // check returned oldest slot, drop if aged
    logic append;     // write new time, update entry, compute alert
    logic emit;       // load output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ignore;     // frame gives no result
    logic scan_done;  // key hit or last entry examined
    logic ring_empty; // ring count is zero
    logic aged;       // oldest slot is out of window
    logic alert;      // alert raised by append
  } status_t;

endpackage

/* rtl/core/mffd_ctrl.sv */
// ---------------------------------------------------------------------------
// mffd_ctrl
// Sequencer: entry search, eviction walk, append and result hand-off.
// ---------------------------------------------------------------------------
module mffd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mffd_pkg::cmd_t    cmd,
  input  mffd_pkg::status_t status
);
  import mffd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SCAN, S_CLAIM, S_READ, S_WAIT, S_EVICT, S_APPEND
  } state_t;

  state_t state;
  logic   out_valid_r;
  logic   out_valid_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = out_valid_r;

  // Decode commands from state
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.load = in_valid;
      S_SCAN:   cmd.scan = 1'b1;
      S_CLAIM:  cmd.claim = 1'b1;
      S_READ:   cmd.rd_ring = 1'b1;
      S_EVICT:  cmd.evict = 1'b1;
      S_APPEND: cmd.append = 1'b1;
      default:  cmd = '0;
    endcase
    cmd.emit = (state == S_APPEND) && status.alert;
  end

  // Hold a waiting word, set valid when an alert commits
  always_comb begin
    out_valid_next = out_valid_r && !out_ready;
    if ((state == S_APPEND) && !(out_valid_r && !out_ready) && status.alert) begin
      out_valid_next = 1'b1;
    end
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_next;
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_CHECK;
        end
        S_CHECK: begin
          state <= status.ignore ? S_IDLE : S_SCAN;
        end
        S_SCAN: begin
          if (status.scan_done) state <= S_CLAIM;
        end
        S_CLAIM: begin
          state <= S_READ;
        end
        S_READ: begin
          state <= status.ring_empty ? S_APPEND : S_WAIT;
        end
        S_WAIT: begin
          state <= S_EVICT;
        end
        S_EVICT: begin
          state <= status.aged ? S_READ : S_APPEND;
        end
        S_APPEND: begin
          // wait until the output register is free before committing
          if (!(out_valid_r && !out_ready)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/mffd_datapath.sv */
// ---------------------------------------------------------------------------
// mffd_datapath
// Entry table, ring memory, config registers and result register.
// ---------------------------------------------------------------------------
module mffd_datapath #(
  parameter int ENTRIES_PER_RULE = 4,
  parameter int WINDOW_DEPTH     = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  mffd_pkg::in_word_t  in_word,
  input  mffd_pkg::cmd_t      cmd,
  input  logic                out_busy,
  output mffd_pkg::status_t   status,
  output mffd_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  output logic [31:0]         cfg_rdata
);
  import mffd_pkg::*;

  localparam int ENTRY_TOTAL = RULE_COUNT * ENTRIES_PER_RULE;
  localparam int EW = (ENTRY_TOTAL > 1) ? $clog2(ENTRY_TOTAL) : 1;
  localparam int LW = (ENTRIES_PER_RULE > 1) ? $clog2(ENTRIES_PER_RULE) : 1;
  localparam int RW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int MW = EW + RW;
  // each entry owns a power-of-two block so {entry, slot} addresses it
  localparam int MEM_DEPTH = ENTRY_TOTAL * (2 ** RW);
  localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

  // Configuration registers
  logic [31:0] window_ms, cooldown_ms;
  logic [15:0] thr [RULE_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms   <= 32'd1000;
      cooldown_ms <= 32'd5000;
      thr[0] <= 16'd20;
      thr[1] <= 16'd20;
      thr[2] <= 16'd20;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WINDOW:   window_ms   <= cfg_data;
        REG_COOLDOWN: cooldown_ms <= cfg_data;
        REG_DEAUTH:   thr[0] <= cfg_data[15:0];
        REG_DISASSOC: thr[1] <= cfg_data[15:0];
        REG_AUTH:     thr[2] <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WINDOW:   cfg_rdata = window_ms;
      REG_COOLDOWN: cfg_rdata = cooldown_ms;
      REG_DEAUTH:   cfg_rdata = {16'd0, thr[0]};
      REG_DISASSOC: cfg_rdata = {16'd0, thr[1]};
      REG_AUTH:     cfg_rdata = {16'd0, thr[2]};
      default:      cfg_rdata = '0;
    endcase
  end

  // Entry table
  logic          e_use    [ENTRY_TOTAL];
  logic [7:0]    e_chan   [ENTRY_TOTAL];
  logic [47:0]   e_bssid  [ENTRY_TOTAL];
  logic [47:0]   e_sender [ENTRY_TOTAL];
  logic [31:0]   e_seen   [ENTRY_TOTAL];
  logic          e_alrt   [ENTRY_TOTAL];
  logic [31:0]   e_lalrt  [ENTRY_TOTAL];
  logic [RW-1:0] e_head   [ENTRY_TOTAL];
  logic [CW-1:0] e_cnt    [ENTRY_TOTAL];

  // Captured frame and search state
  in_word_t      fr;
  logic [1:0]    rule;
  logic [LW-1:0] scan_i;
  logic [EW-1:0] sel;        // working entry
  logic          hit, have_free;
  logic [EW-1:0] free_e, old_e;
  logic [31:0]   old_age;
  logic [RW-1:0] head;
  logic [CW-1:0] cnt;
  logic [31:0]   rd_data;

  logic [1:0] rule_dec;
  always_comb begin
    case (in_word.frame_subtype)
      SUBTYPE_DEAUTH:   rule_dec = RULE_DEAUTH;
      SUBTYPE_DISASSOC: rule_dec = RULE_DISASSOC;
      SUBTYPE_AUTH:     rule_dec = RULE_AUTH;
      default:          rule_dec = RULE_NONE;
    endcase
  end

  logic [EW-1:0] base_e, cur_e;
  logic [31:0]   cur_age;
  assign base_e  = EW'(rule * ENTRIES_PER_RULE);
  assign cur_e   = base_e + EW'(scan_i);
  assign cur_age = fr.time_ms - e_seen[cur_e];

  logic [15:0] rule_thr;
  assign rule_thr = (rule == RULE_NONE) ? 16'd0 : thr[rule];

  assign status.ignore = (rule == RULE_NONE) || (fr.frame_length < MIN_FRAME_LEN) ||
                         (window_ms == 32'd0) || (rule_thr == 16'd0);
  assign status.scan_done  = hit || (scan_i == LW'(ENTRIES_PER_RULE - 1));
  assign status.ring_empty = (cnt == '0);
  assign status.aged       = (fr.time_ms - rd_data) >= window_ms;

  // Append arithmetic
  logic          full;
  logic [RW-1:0] head_a, wr_slot;
  logic [CW-1:0] cnt_a, cnt_new;
  logic          cool;
  logic [RW:0]   slot_sum;
  assign full     = (cnt >= DEPTH_C);
  assign head_a   = full ? ((head == RW'(WINDOW_DEPTH - 1)) ? '0 : head + 1'b1) : head;
  assign cnt_a    = full ? DEPTH_C - 1'b1 : cnt;
  assign slot_sum = {1'b0, head_a} + (RW+1)'(cnt_a);
  assign wr_slot  = (slot_sum >= (RW+1)'(WINDOW_DEPTH)) ?
                    RW'(slot_sum - (RW+1)'(WINDOW_DEPTH)) : RW'(slot_sum);
  assign cnt_new  = cnt_a + 1'b1;
  assign cool     = !e_alrt[sel] || ((fr.time_ms - e_lalrt[sel]) >= cooldown_ms);
  assign status.alert = cmd.append && ({{(16 > CW ? 16 - CW : 0){1'b0}}, cnt_new} >= rule_thr)
                        && cool;

  // Ring memory, one port each way, registered read
  logic [31:0] ring [MEM_DEPTH];
  logic [MW-1:0] rd_addr;
  assign rd_addr = {sel, head};

  always_ff @(posedge clk) begin
    if (cmd.rd_ring) rd_data <= ring[rd_addr];
    if (cmd.append)  ring[{sel, wr_slot}] <= fr.time_ms;
  end

  // Search, eviction walk and entry update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRY_TOTAL; i++) begin
        e_use[i] <= 1'b0; e_chan[i] <= '0; e_bssid[i] <= '0; e_sender[i] <= '0;
        e_seen[i] <= '0; e_alrt[i] <= 1'b0; e_lalrt[i] <= '0;
        e_head[i] <= '0; e_cnt[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        fr        <= in_word;
        rule      <= rule_dec;
        scan_i    <= '0;
        hit       <= 1'b0;
        have_free <= 1'b0;
      end
      if (cmd.scan) begin
        if (e_use[cur_e] && e_chan[cur_e] == fr.radio_channel &&
            e_bssid[cur_e] == fr.bss_address) begin
          hit <= 1'b1;
          sel <= cur_e;
        end else begin
          if (!e_use[cur_e] && !have_free) begin
            have_free <= 1'b1;
            free_e    <= cur_e;
          end
          if (scan_i == '0 || cur_age > old_age) begin
            old_e   <= cur_e;
            old_age <= cur_age;
          end
          scan_i <= scan_i + 1'b1;
        end
      end
      if (cmd.claim) begin
        if (hit) begin
          head <= e_head[sel];
          cnt  <= e_cnt[sel];
        end else begin
          sel <= have_free ? free_e : old_e;
          e_use[have_free ? free_e : old_e]    <= 1'b1;
          e_chan[have_free ? free_e : old_e]   <= fr.radio_channel;
          e_bssid[have_free ? free_e : old_e]  <= fr.bss_address;
          e_sender[have_free ? free_e : old_e] <= fr.source_address;
          e_alrt[have_free ? free_e : old_e]   <= 1'b0;
          e_lalrt[have_free ? free_e : old_e]  <= '0;
          head <= '0;
          cnt  <= '0;
        end
      end
      if (cmd.evict && status.aged) begin
        head <= (head == RW'(WINDOW_DEPTH - 1)) ? '0 : head + 1'b1;
        cnt  <= cnt - 1'b1;
      end
      if (cmd.append && !out_busy) begin
        e_head[sel] <= head_a;
        e_cnt[sel]  <= cnt_new;
        e_seen[sel] <= fr.time_ms;
        if (status.alert) begin
          e_alrt[sel]  <= 1'b1;
          e_lalrt[sel] <= fr.time_ms;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit && !out_busy) begin
      out_word.attack_kind     <= rule;
      out_word.detected_at_ms  <= fr.time_ms;
      out_word.count_in_window <= 7'(cnt_new);
      out_word.alert_channel   <= e_chan[sel];
      out_word.alert_subtype   <= fr.frame_subtype;
      out_word.alert_bssid     <= e_bssid[sel];
      out_word.alert_sender    <= e_sender[sel];
    end
  end

endmodule

/* rtl/core/mgmt_frame_flood_detector_top.sv */
// ---------------------------------------------------------------------------
// mgmt_frame_flood_detector_top
// Per-BSSID sliding-window flood detector for deauth, disassoc and auth.
// ---------------------------------------------------------------------------
// A frame passes the check, entry search, claim, eviction walk and append steps
// in that order before the input is ready again. The eviction walk drops each
// timestamp aged out of the entry's window (up to WINDOW_DEPTH) and stops when
// the ring is empty or at a timestamp still inside the window. A key hit on an
// early entry ends the search sooner. The eviction walk reads the ring memory
// one slot at a time through a registered read port. Ignored frames return to
// idle after the check step. A finished alert sits in an output register; a
// frame that reaches its final step while the previous alert is still untaken
// waits there. Ring slots need no clearing: only slots within the fill count are
// ever checked for age.
module mgmt_frame_flood_detector_top #(
  parameter int ENTRIES_PER_RULE = 4,
  parameter int WINDOW_DEPTH     = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mffd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mffd_pkg::out_word_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mffd_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  mffd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .cmd, .status
  );

  mffd_datapath #(
    .ENTRIES_PER_RULE(ENTRIES_PER_RULE),
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_dp (
    .clk, .rst,
    .in_word(in_data),
    .cmd, .out_busy(out_valid && !out_ready), .status,
    .out_word(out_data),
    .cfg_we, .cfg_idx(paddr[4:2]), .cfg_data(pwdata), .cfg_rdata(prdata)
  );

endmodule

/* rtl/core/mffd_checker.sv */
// ---------------------------------------------------------------------------
// mffd_checker
// Port-level checks of the flood detector.
// ---------------------------------------------------------------------------
module mffd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mffd_pkg::out_word_t out_data,
  input logic                pready
);
  import mffd_pkg::*;

  // an alert is never for an unknown rule
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.attack_kind != RULE_NONE)) else $error("bad kind");

  // an alert always counts at least one frame
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.count_in_window != 7'd0)) else $error("zero count");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("drop");

  // no new item is taken in the cycle after one was taken
  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("back to back");

  a_pready: assert property (@(posedge clk) pready) else $error("pready low");

endmodule

bind mgmt_frame_flood_detector_top mffd_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_data, .pready
);

/* tb/flood_checker.sv */
// ---------------------------------------------------------------------------
// flood_checker
// Watches the frame and alert channels and the register port, keeps a model
// of the per-BSSID window tables and compares every alert word in order.
// ---------------------------------------------------------------------------
module flood_checker #(
  parameter int ENTRIES_PER_RULE = 4,
  parameter int WINDOW_DEPTH     = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mffd_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mffd_pkg::out_word_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  alerts_pending
);
  import mffd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL = RULE_COUNT * ENTRIES_PER_RULE;

  logic [31:0] win_len, cool_len;
  logic [15:0] thr [RULE_COUNT];

  logic        used      [TOTAL];
  logic [7:0]  chan      [TOTAL];
  logic [47:0] bssid     [TOTAL];
  logic [47:0] sender    [TOTAL];
  logic [31:0] seen      [TOTAL];
  logic        alerted   [TOTAL];
  logic [31:0] alert_at  [TOTAL];
  int          head      [TOTAL];
  int          fill      [TOTAL];
  logic [31:0] stamps    [TOTAL][WINDOW_DEPTH];

  out_word_t alert_q[$];

  assign alerts_pending = alert_q.size();

  function automatic int rule_for(logic [3:0] st);
    case (st)
      SUBTYPE_DEAUTH:   return RULE_DEAUTH;
      SUBTYPE_DISASSOC: return RULE_DISASSOC;
      SUBTYPE_AUTH:     return RULE_AUTH;
      default:          return -1;
    endcase
  endfunction

  // Find or claim the entry for this frame's key
  function automatic int find_entry(int rule, in_word_t w);
    int base, oldest, free_idx, e;
    logic [31:0] best_age, age;
    base = rule * ENTRIES_PER_RULE;
    oldest = base;
    free_idx = -1;
    best_age = w.time_ms - seen[base];
    for (int i = 0; i < ENTRIES_PER_RULE; i++) begin
      e = base + i;
      if (used[e] && chan[e] == w.radio_channel && bssid[e] == w.bss_address)
        return e;
      if (!used[e] && free_idx < 0) free_idx = e;
      age = w.time_ms - seen[e];
      if (age > best_age) begin
        oldest = e;
        best_age = age;
      end
    end
    e = (free_idx >= 0) ? free_idx : oldest;
    used[e] = 1'b1;
    chan[e] = w.radio_channel;
    bssid[e] = w.bss_address;
    sender[e] = w.source_address;
    seen[e] = '0;
    alerted[e] = 1'b0;
    alert_at[e] = '0;
    head[e] = 0;
    fill[e] = 0;
    return e;
  endfunction

  // Advance the window of one entry and queue an alert if one is due
  task automatic predict_frame(in_word_t w);
    int rule, e;
    logic [31:0] age;
    logic cool;
    out_word_t r;
    rule = rule_for(w.frame_subtype);
    if (rule < 0 || w.frame_length < MIN_FRAME_LEN || win_len == 0) return;
    if (thr[rule] == 0) return;
    e = find_entry(rule, w);
    while (fill[e] > 0) begin
      age = w.time_ms - stamps[e][head[e]];
      if (age < win_len) break;
      head[e] = (head[e] + 1) % WINDOW_DEPTH;
      fill[e]--;
    end
    if (fill[e] >= WINDOW_DEPTH) begin
      head[e] = (head[e] + 1) % WINDOW_DEPTH;
      fill[e] = WINDOW_DEPTH - 1;
    end
    stamps[e][(head[e] + fill[e]) % WINDOW_DEPTH] = w.time_ms;
    fill[e]++;
    seen[e] = w.time_ms;
    age = w.time_ms - alert_at[e];
    cool = !alerted[e] || age >= cool_len;
    if (fill[e] < thr[rule] || !cool) return;
    alerted[e] = 1'b1;
    alert_at[e] = w.time_ms;
    r.attack_kind = rule[1:0];
    r.detected_at_ms = w.time_ms;
    r.count_in_window = fill[e][6:0];
    r.alert_channel = chan[e];
    r.alert_subtype = w.frame_subtype;
    r.alert_bssid = bssid[e];
    r.alert_sender = sender[e];
    alert_q.push_back(r);
  endtask

  task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      win_len = 32'd1000;
      cool_len = 32'd5000;
      for (int i = 0; i < RULE_COUNT; i++) thr[i] = 16'd20;
      for (int i = 0; i < TOTAL; i++) begin
        used[i] = 0; chan[i] = 0; bssid[i] = 0; sender[i] = 0; seen[i] = 0;
        alerted[i] = 0; alert_at[i] = 0; head[i] = 0; fill[i] = 0;
      end
      alert_q.delete();
      fail_count = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_WINDOW:   win_len = pwdata;
          REG_COOLDOWN: cool_len = pwdata;
          REG_DEAUTH:   thr[RULE_DEAUTH] = pwdata[15:0];
          REG_DISASSOC: thr[RULE_DISASSOC] = pwdata[15:0];
          REG_AUTH:     thr[RULE_AUTH] = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_frame(in_data);
      // compare alert words
      if (out_valid && out_ready) begin
        if (alert_q.size() == 0) begin
          $display("%0t: unexpected alert word, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          e = alert_q.pop_front();
          check_field("attack_kind", e.attack_kind, out_data.attack_kind);
          check_field("detected_at_ms", e.detected_at_ms, out_data.detected_at_ms);
          check_field("count_in_window", e.count_in_window, out_data.count_in_window);
          check_field("alert_channel", e.alert_channel, out_data.alert_channel);
          check_field("alert_subtype", e.alert_subtype, out_data.alert_subtype);
          check_field("alert_bssid", e.alert_bssid, out_data.alert_bssid);
          check_field("alert_sender", e.alert_sender, out_data.alert_sender);
        end
      end
    end
  end
endmodule

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Drives frame bursts against the flood detector under several register
// settings, with random idle bursts on both sides and one long output stall.
// ---------------------------------------------------------------------------
module tb_top;
  import mffd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  in_word_t    in_data;
  out_word_t   out_data;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, alerts_pending;

  bit          quiet;      // no idling in the last part
  bit          hold_off;   // long receiver stall
  logic [31:0] clock_ms;

  logic [47:0] bss_pool [4];
  logic [7:0]  chan_pool [4];

  mgmt_frame_flood_detector_top dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  flood_checker chk (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .alerts_pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stall bursts, plus the long hold-off
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 0;
      else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ready <= 1;
      end else out_ready <= 1;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // Offer one frame word and hold it until taken
  task automatic send_frame(in_word_t w);
    if (!quiet && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 14)) @(posedge clk);
    in_valid <= 1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    in_valid <= 0;
    @(posedge clk);
  endtask

  // Wait until every alert has come, then let a worst-case frame drain
  task automatic drain();
    while (alerts_pending != 0) @(posedge clk);
    repeat (5 + 4 + 3 * 64 + 20) @(posedge clk);
  endtask

  function automatic in_word_t make_frame(bit wellformed);
    in_word_t w;
    int k;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    if (wellformed) begin
      k = $urandom_range(0, 3);
      case ($urandom_range(0, 2))
        0: w.frame_subtype = SUBTYPE_DEAUTH;
        1: w.frame_subtype = SUBTYPE_DISASSOC;
        default: w.frame_subtype = SUBTYPE_AUTH;
      endcase
      if ($urandom_range(0, 9) != 0) begin
        w.bss_address = bss_pool[k];
        w.radio_channel = chan_pool[k];
      end
      w.frame_length = 16'($urandom_range(24, 65535));
      if ($urandom_range(0, 30) == 0) w.frame_length = 16'd24;
      clock_ms += $urandom_range(0, 60);
      w.time_ms = clock_ms;
    end
    return w;
  endfunction

  task automatic random_phase(int n, logic [31:0] win, logic [31:0] cool, logic [15:0] t);
    drain();
    reg_write(REG_WINDOW, win);
    reg_write(REG_COOLDOWN, cool);
    reg_write(REG_DEAUTH, 32'(t));
    reg_write(REG_DISASSOC, 32'(t) + $urandom_range(0, 2));
    reg_write(REG_AUTH, (t > 16'd1) ? 32'(t - 16'd1) : 32'(t));
    for (int i = 0; i < n; i++) send_frame(make_frame($urandom_range(0, 9) != 0));
  endtask

  initial begin
    in_word_t w;
    rst = 1; in_valid = 0; in_data = '0; psel = 0; penable = 0; pwrite = 0;
    paddr = '0; pwdata = '0; quiet = 0; hold_off = 0; clock_ms = 32'hFFFF_F000;
    for (int i = 0; i < 4; i++) begin
      bss_pool[i] = 48'({$urandom, $urandom});
      chan_pool[i] = 8'($urandom);
    end
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: small thresholds, every subtype, short and long frames
    reg_write(REG_WINDOW, 32'd100);
    reg_write(REG_COOLDOWN, 32'd0);
    reg_write(REG_DEAUTH, 32'd1);
    reg_write(REG_DISASSOC, 32'd2);
    reg_write(REG_AUTH, 32'd65535);
    for (int i = 0; i < 16; i++) begin
      w = '0;
      w.frame_subtype = 4'(i);
      w.radio_channel = (i & 1) ? 8'hFF : 8'h00;
      w.bss_address = (i & 2) ? 48'hFFFF_FFFF_FFFF : 48'h0;
      w.source_address = (i & 1) ? 48'hFFFF_FFFF_FFFF : 48'h0;
      w.time_ms = 32'hFFFF_FFF0 + 32'(i * 8);   // crosses the wrap
      w.frame_length = (i == 3) ? 16'd23 : ((i & 4) ? 16'hFFFF : 16'd24);
      send_frame(w);
    end
    // Five distinct keys on one rule forces replacement of the stalest entry
    for (int i = 0; i < 6; i++) begin
      w = '0;
      w.frame_subtype = SUBTYPE_DISASSOC;
      w.bss_address = 48'(i % 5);
      w.time_ms = 32'd20 + 32'(i);
      w.frame_length = 16'd100;
      send_frame(w);
    end

    // Zero window disables everything
    random_phase(60, 32'd0, 32'd10, 16'd1);
    // Zero threshold disables a rule; long stall fills the output
    random_phase(20, 32'd500, 32'd0, 16'd0);
    drain();
    reg_write(REG_DEAUTH, 32'd1);
    hold_off = 1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
    join_none
    for (int i = 0; i < 40; i++) send_frame(make_frame(1));
    // Full ring with a huge window; threshold beyond the depth
    random_phase(300, 32'hFFFF_FFFF, 32'd0, 16'd64);
    random_phase(200, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd65);
    random_phase(400, 32'd400, 32'd200, 16'd3);
    random_phase(400, 32'd1000, 32'd5000, 16'd5);
    quiet = 1;
    random_phase(400, 32'd150, 32'd50, 16'd2);
    drain();

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
